/* rtl/core/icmp_echo_receive_checker_defines.svh */
// Assertion macros shared by the checker modules.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef ICMP_ECHO_RECEIVE_CHECKER_DEFINES_SVH
`define ICMP_ECHO_RECEIVE_CHECKER_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define ICMPE_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define ICMPE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/icmpe_pkg.sv */
package icmpe_pkg;

	localparam int unsigned POS_W = 4;

	localparam logic [POS_W-1:0] HDR_LEN      = 4'd8;
	localparam logic [POS_W-1:0] POS_TYPE     = 4'd0;
	localparam logic [POS_W-1:0] POS_CODE     = 4'd1;
	localparam logic [POS_W-1:0] POS_IDENT_HI = 4'd4;
	localparam logic [POS_W-1:0] POS_IDENT_LO = 4'd5;
	localparam logic [POS_W-1:0] POS_SEQ_HI   = 4'd6;
	localparam logic [POS_W-1:0] POS_SEQ_LO   = 4'd7;

	localparam logic [7:0]  TYPE_REQUEST = 8'd8;
	localparam logic [7:0]  TYPE_REPLY   = 8'd0;
	localparam logic [15:0] CSUM_GOOD    = 16'hffff;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_SHORT = 3'd1,
		ST_TYPE  = 3'd2,
		ST_CODE  = 3'd3,
		ST_CSUM  = 3'd4
	} status_t;

	// One result item as it leaves the parser.
	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        payload_valid;
		logic        message_done;
		status_t     status;
		logic        echo_kind;
		logic [15:0] identifier;
		logic [15:0] sequence_res;
	} res_t;

endpackage

/* rtl/core/icmp_echo_receive_checker.sv */
// ICMP echo receive checker.
//
// The input channel carries one item per message byte, in wire order, with
// last_byte set on the final byte. The output channel carries a result item
// for every payload byte (those beyond the eight-byte header) and for the
// final byte, which also carries the verdict: status, echo kind, identifier
// and sequence number. Header bytes that are not final give no result item.
// Both channels use valid and stall; an item moves on a clock edge where
// valid is high and stall is low.
// An accepted byte sits in the input register, where the checksum add and
// header capture are done on it combinationally; its result is then
// written into the output register and offered from there. One byte is
// taken every cycle while the receiver keeps up.
// While a result waits under stall the input register still holds one more
// byte before in_stall rises; bytes that produce no result never wait.
// Reset clears the valid bits of both registers and the parse state, so the
// first byte after reset starts a new message. No clearing pass is needed.

`include "icmp_echo_receive_checker_defines.svh"

module icmp_echo_receive_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  payload_byte,
	output logic        payload_valid,
	output logic        message_done,
	output logic [2:0]  status,
	output logic        echo_kind,
	output logic [15:0] identifier,
	output logic [15:0] sequence_res
);

	// Input register stage.
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;

	// Result register.
	logic            out_valid_q;
	icmpe_pkg::res_t res_q;

	icmpe_pkg::res_t res;
	logic            has_res;
	logic            out_free;
	logic            commit;

	icmpe_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.commit    (commit),
		.res       (res)
	);

	// A byte leaves the input register when its result has somewhere to go,
	// or straight away when it produces no result at all.
	always_comb begin
		has_res  = res.payload_valid | res.message_done;
		out_free = !out_valid_q || !out_stall;
		commit   = valid_s1 && (out_free || !has_res);
		in_stall = valid_s1 && !commit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (commit && has_res) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
		if (commit && has_res) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign payload_byte  = res_q.payload_byte;
	assign payload_valid = res_q.payload_valid;
	assign message_done  = res_q.message_done;
	assign status        = res_q.status;
	assign echo_kind     = res_q.echo_kind;
	assign identifier    = res_q.identifier;
	assign sequence_res  = res_q.sequence_res;

	`ICMPE_ASSERT_IMPLIES(a_result_not_empty, out_valid, payload_valid || message_done, "empty result offered")
	`ICMPE_ASSERT_IMPLIES(a_fields_zero_on_fail, out_valid && status != icmpe_pkg::ST_OK, !echo_kind && identifier == 16'd0 && sequence_res == 16'd0, "echo fields set on a failed message")
	`ICMPE_ASSERT_IMPLIES(a_stall_cause, in_stall, valid_s1 && out_valid && out_stall, "input stalled without a blocked result")

endmodule

/* rtl/core/icmpe_parse.sv */
`include "icmp_echo_receive_checker_defines.svh"

module icmpe_parse (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         data_byte,
	input  logic               last_byte,
	input  logic               commit,
	output icmpe_pkg::res_t    res
);

	logic [icmpe_pkg::POS_W-1:0] pos_q;
	logic                        odd_q;
	logic [15:0]                 sum_q;
	logic [7:0]                  type_q;
	logic [7:0]                  code_q;
	logic [15:0]                 ident_q;
	logic [15:0]                 seq_q;

	logic [15:0] addend;
	logic [16:0] sum_wide;
	logic [15:0] sum_next;
	logic [7:0]  type_next;
	logic [7:0]  code_next;
	logic [15:0] ident_next;
	logic [15:0] seq_next;
	logic        pay;
	icmpe_pkg::status_t st;

	// The checksum is summed big-endian: an even byte is the high half of its word.
	always_comb begin
		addend   = odd_q ? {8'h00, data_byte} : {data_byte, 8'h00};
		sum_wide = {1'b0, sum_q} + {1'b0, addend};
		sum_next = sum_wide[15:0] + {15'd0, sum_wide[16]};
	end

	always_comb begin
		type_next  = type_q;
		code_next  = code_q;
		ident_next = ident_q;
		seq_next   = seq_q;
		case (pos_q)
			icmpe_pkg::POS_TYPE: type_next = data_byte;
			icmpe_pkg::POS_CODE: code_next = data_byte;
			icmpe_pkg::POS_IDENT_HI, icmpe_pkg::POS_IDENT_LO: ident_next = {ident_q[7:0], data_byte};
			icmpe_pkg::POS_SEQ_HI, icmpe_pkg::POS_SEQ_LO: seq_next = {seq_q[7:0], data_byte};
			default: ;
		endcase
	end

	// The verdict uses the header and sum as they stand after this byte.
	always_comb begin
		pay = (pos_q >= icmpe_pkg::HDR_LEN);
		if (pos_q < icmpe_pkg::POS_SEQ_LO) begin
			st = icmpe_pkg::ST_SHORT;
		end else if (type_next != icmpe_pkg::TYPE_REQUEST && type_next != icmpe_pkg::TYPE_REPLY) begin
			st = icmpe_pkg::ST_TYPE;
		end else if (code_next != 8'd0) begin
			st = icmpe_pkg::ST_CODE;
		end else if (sum_next != icmpe_pkg::CSUM_GOOD) begin
			st = icmpe_pkg::ST_CSUM;
		end else begin
			st = icmpe_pkg::ST_OK;
		end

		res               = '0;
		res.payload_valid = pay;
		res.payload_byte  = pay ? data_byte : 8'd0;
		res.message_done  = last_byte;
		res.status        = last_byte ? st : icmpe_pkg::ST_OK;
		if (last_byte && st == icmpe_pkg::ST_OK) begin
			res.echo_kind    = (type_next == icmpe_pkg::TYPE_REPLY);
			res.identifier   = ident_next;
			res.sequence_res = seq_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			odd_q   <= 1'b0;
			sum_q   <= '0;
			type_q  <= '0;
			code_q  <= '0;
			ident_q <= '0;
			seq_q   <= '0;
		end else if (commit) begin
			if (last_byte) begin
				pos_q   <= '0;
				odd_q   <= 1'b0;
				sum_q   <= '0;
				type_q  <= '0;
				code_q  <= '0;
				ident_q <= '0;
				seq_q   <= '0;
			end else begin
				if (!pay) begin
					pos_q <= pos_q + 4'd1;
				end
				odd_q   <= ~odd_q;
				sum_q   <= sum_next;
				type_q  <= type_next;
				code_q  <= code_next;
				ident_q <= ident_next;
				seq_q   <= seq_next;
			end
		end
	end

	`ICMPE_ASSERT_IMPLIES(a_pos_saturates, 1'b1, pos_q <= icmpe_pkg::HDR_LEN, "byte position beyond header length")
	`ICMPE_ASSERT_NEXT(a_last_clears, commit && last_byte, pos_q == '0 && sum_q == '0 && !odd_q, "state not cleared after final byte")
	`ICMPE_ASSERT_IMPLIES(a_header_no_payload, !res.payload_valid, res.payload_byte == 8'd0, "header byte leaked as payload")

endmodule

/* tb/testbench.sv */
module testbench;

	// Minimum number of message bytes in the random part, and a hard ceiling on the run.
	localparam int RANDOM_BYTES = 1900;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int REPORT_MAX   = 10;

	// One item for the input channel: a message byte, its last mark, the idling
	// phase it belongs to, and whether the sender must first wait for every
	// outstanding result to come back.
	typedef struct {
		logic [7:0] value;
		logic       fin;
		int         ph;
		bit         hold;
	} wire_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  payload_byte;
	logic        payload_valid;
	logic        message_done;
	logic [2:0]  status;
	logic        echo_kind;
	logic [15:0] identifier;
	logic [15:0] sequence_res;

	icmp_echo_receive_checker u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.payload_byte (payload_byte),
		.payload_valid(payload_valid),
		.message_done (message_done),
		.status       (status),
		.echo_kind    (echo_kind),
		.identifier   (identifier),
		.sequence_res (sequence_res)
	);

	// Period of four time units.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Bytes waiting to be offered, and the results the parser still owes us.
	wire_byte_t        bytes_to_send[$];
	icmpe_pkg::res_t   parser_results_due[$];
	wire_byte_t        next_byte;
	logic [7:0]        msg_bytes[$];
	int                bytes_queued = 0;
	int                cur_phase = 0;
	logic              byte_taken = 1'b0;
	int                mismatch_count = 0;
	int                cycle_count = 0;

	// Parse state of our own copy of the receiver.
	logic [3:0]  pos_cnt = '0;
	logic        odd_half = 1'b0;
	logic [15:0] csum_acc = '0;
	logic [7:0]  hdr_type = '0;
	logic [7:0]  hdr_code = '0;
	logic [15:0] hdr_ident = '0;
	logic [15:0] hdr_seq = '0;

	// Ones' complement add with the carry folded back into the low end.
	function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

	// Percentage of cycles in which a side idles, by phase: the sender is
	// lightly idle and the receiver heavily stalled first, then the reverse,
	// then both run flat out.
	function automatic int idle_pct(input int ph, input bit sender);
		if (ph == 0) begin
			return sender ? 19 : 54;
		end else if (ph == 1) begin
			return sender ? 54 : 19;
		end
		return 0;
	endfunction

	// Adds one byte to the end of the message being built.
	task automatic append_msg_byte(input logic [7:0] b);
		msg_bytes.insert(msg_bytes.size(), b);
	endtask

	// Works out what the parser must produce for one accepted byte and queues
	// it. Header bytes that are not final leave nothing behind.
	task automatic parse_byte(input logic [7:0] b, input logic fin);
		icmpe_pkg::res_t    r;
		logic [3:0]         at;
		logic               beyond;
		icmpe_pkg::status_t verdict;
		at = pos_cnt;
		beyond = (at >= icmpe_pkg::HDR_LEN);
		// Even positions are the high half of a big-endian word, odd ones the low.
		csum_acc = ones_add(csum_acc, odd_half ? {8'h00, b} : {b, 8'h00});
		odd_half = ~odd_half;
		case (at)
			icmpe_pkg::POS_TYPE: hdr_type = b;
			icmpe_pkg::POS_CODE: hdr_code = b;
			icmpe_pkg::POS_IDENT_HI, icmpe_pkg::POS_IDENT_LO:
				hdr_ident = {hdr_ident[7:0], b};
			icmpe_pkg::POS_SEQ_HI, icmpe_pkg::POS_SEQ_LO:
				hdr_seq = {hdr_seq[7:0], b};
			default: ;
		endcase
		if (!beyond) begin
			pos_cnt = at + 4'd1;
		end
		if (beyond || fin) begin
			r = '0;
			if (beyond) begin
				r.payload_byte = b;
				r.payload_valid = 1'b1;
			end
			if (fin) begin
				// The verdicts are tried strictly in this order.
				if (int'(at) + 1 < int'(icmpe_pkg::HDR_LEN)) begin
					verdict = icmpe_pkg::ST_SHORT;
				end else if (hdr_type != icmpe_pkg::TYPE_REQUEST
						&& hdr_type != icmpe_pkg::TYPE_REPLY) begin
					verdict = icmpe_pkg::ST_TYPE;
				end else if (hdr_code != 8'h00) begin
					verdict = icmpe_pkg::ST_CODE;
				end else if (csum_acc != icmpe_pkg::CSUM_GOOD) begin
					verdict = icmpe_pkg::ST_CSUM;
				end else begin
					verdict = icmpe_pkg::ST_OK;
				end
				r.message_done = 1'b1;
				r.status = verdict;
				if (verdict == icmpe_pkg::ST_OK) begin
					r.echo_kind = (hdr_type == icmpe_pkg::TYPE_REPLY);
					r.identifier = hdr_ident;
					r.sequence_res = hdr_seq;
				end
				// The next byte opens a fresh message.
				pos_cnt = '0;
				odd_half = 1'b0;
				csum_acc = '0;
				hdr_type = '0;
				hdr_code = '0;
				hdr_ident = '0;
				hdr_seq = '0;
			end
			parser_results_due.insert(parser_results_due.size(), r);
		end
	endtask

	// Compares one result item on the output ports with the oldest expectation.
	task automatic check_result(input icmpe_pkg::res_t want);
		bit bad;
		bad = (payload_byte !== want.payload_byte) || (payload_valid !== want.payload_valid)
			|| (message_done !== want.message_done) || (status !== want.status)
			|| (echo_kind !== want.echo_kind) || (identifier !== want.identifier)
			|| (sequence_res !== want.sequence_res);
		if (bad) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_MAX) begin
				$display("mismatch: expected pay %h/%b done %b st %0d kind %b id %h seq %h",
					want.payload_byte, want.payload_valid, want.message_done, want.status,
					want.echo_kind, want.identifier, want.sequence_res);
				$display("          got      pay %h/%b done %b st %0d kind %b id %h seq %h",
					payload_byte, payload_valid, message_done, status, echo_kind,
					identifier, sequence_res);
			end
		end
	endtask

	// Writes the internet checksum into bytes two and three so that the whole
	// message folds to all ones.
	task automatic seal_checksum();
		logic [15:0] acc;
		acc = '0;
		msg_bytes[2] = 8'h00;
		msg_bytes[3] = 8'h00;
		foreach (msg_bytes[i]) begin
			acc = ones_add(acc, i[0] ? {8'h00, msg_bytes[i]} : {msg_bytes[i], 8'h00});
		end
		acc = ~acc;
		msg_bytes[2] = acc[15:8];
		msg_bytes[3] = acc[7:0];
	endtask

	// Builds a well-formed echo message with random identifier, sequence and
	// payload.
	task automatic make_echo(input bit reply, input int plen);
		msg_bytes.delete();
		append_msg_byte(reply ? icmpe_pkg::TYPE_REPLY : icmpe_pkg::TYPE_REQUEST);
		append_msg_byte(8'h00);
		append_msg_byte(8'h00);
		append_msg_byte(8'h00);
		repeat (4 + plen) append_msg_byte(8'($urandom_range(255)));
		seal_checksum();
	endtask

	// Hands the message being built to the driver, one item per byte.
	task automatic send_message(input int ph, input bit hold);
		wire_byte_t w;
		foreach (msg_bytes[i]) begin
			w.value = msg_bytes[i];
			w.fin = (i == msg_bytes.size() - 1);
			w.ph = ph;
			w.hold = hold && (i == 0);
			bytes_to_send.insert(bytes_to_send.size(), w);
			bytes_queued++;
		end
	endtask

	// Driver: a new item goes on the wires only once the previous one has
	// been taken, so a stalled item never changes. Valid is decided without
	// looking at stall.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || byte_taken) begin
				if (bytes_to_send.size() != 0
						&& !(bytes_to_send[0].hold && parser_results_due.size() != 0)
						&& $urandom_range(99) >= idle_pct(cur_phase, 1'b1)) begin
					next_byte = bytes_to_send.pop_front();
					in_valid <= 1'b1;
					data_byte <= next_byte.value;
					last_byte <= next_byte.fin;
					cur_phase <= next_byte.ph;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// The receiver stalls at random at the rate of the current phase.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < idle_pct(cur_phase, 1'b0));
	end

	// Monitor: both handshakes are read at the rising edge. The expectation
	// for an accepted byte is queued before any result is checked.
	always @(posedge clk) begin
		if (arst_n) begin
			byte_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				parse_byte(data_byte, last_byte);
			end
			if (out_valid && !out_stall) begin
				if (parser_results_due.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX) begin
						$display("unexpected result: pay %h/%b done %b st %0d",
							payload_byte, payload_valid, message_done, status);
					end
				end else begin
					check_result(parser_results_due.pop_front());
				end
			end
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int  ph;
		int  last_ph;
		int  kind;
		int  plen;
		int  idx;
		int  keep;
		logic [7:0] t;

		// Directed part. A lone byte and a seven-byte header are both too
		// short; an all-zero header fails the checksum; then a good request
		// with extreme identifier and sequence and an odd payload byte that
		// needs zero padding.
		msg_bytes.delete();
		append_msg_byte(icmpe_pkg::TYPE_REQUEST);
		send_message(0, 1'b0);

		make_echo(1'b0, 0);
		while (msg_bytes.size() > 7) void'(msg_bytes.pop_back());
		send_message(0, 1'b0);

		msg_bytes.delete();
		repeat (8) append_msg_byte(8'h00);
		send_message(0, 1'b0);

		make_echo(1'b0, 1);
		msg_bytes[4] = 8'hff;
		msg_bytes[5] = 8'hff;
		msg_bytes[6] = 8'h00;
		msg_bytes[7] = 8'h00;
		msg_bytes[8] = 8'hff;
		seal_checksum();
		send_message(0, 1'b0);

		// Random part: mostly good echo messages with random content, the
		// rest damaged in one way or another. The sender drains the parser
		// at each change of phase and now and then in between.
		last_ph = 0;
		bytes_queued = 0;
		while (bytes_queued < RANDOM_BYTES) begin
			ph = bytes_queued * 3 / RANDOM_BYTES;
			kind = $urandom_range(99);
			plen = ($urandom_range(19) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 24);
			make_echo($urandom_range(1), plen);
			if (kind < 60) begin
				// left intact
			end else if (kind < 68) begin
				// A single flipped bit anywhere in the message.
				idx = $urandom_range(msg_bytes.size() - 1);
				msg_bytes[idx] = msg_bytes[idx] ^ (8'h01 << $urandom_range(7));
			end else if (kind < 75) begin
				do begin
					t = 8'($urandom_range(255));
				end while (t == icmpe_pkg::TYPE_REQUEST || t == icmpe_pkg::TYPE_REPLY);
				msg_bytes[0] = t;
				if ($urandom_range(1)) seal_checksum();
			end else if (kind < 82) begin
				msg_bytes[1] = 8'($urandom_range(1, 255));
				if ($urandom_range(1)) seal_checksum();
			end else if (kind < 90) begin
				// Cut off inside the header.
				keep = $urandom_range(1, 7);
				while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
			end else begin
				msg_bytes.delete();
				repeat ($urandom_range(1, 30)) append_msg_byte(8'($urandom_range(255)));
			end
			send_message(ph, (ph != last_ph) || ($urandom_range(39) == 0));
			last_ph = ph;
		end

		// Hold reset, then release it at a falling clock edge.
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// All items offered and taken, then every result back, then a last wait
		// so that the monitor can catch any stray output.
		while (bytes_to_send.size() != 0 || in_valid) @(posedge clk);
		while (parser_results_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (parser_results_due.size() != 0) begin
			mismatch_count += parser_results_due.size();
		end

		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/icmpe_pkg.sv
rtl/core/icmpe_parse.sv
rtl/core/icmp_echo_receive_checker.sv
tb/testbench.sv
